### rtl/pasm_pkg.sv
package pasm_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int MAX_DEGREE  = 15;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 36;
   localparam int IDX_W       = 4;
   localparam int DEG_W       = 5;

   localparam logic [IDX_W-1:0] BASE_DEGREE = 4'd5;

   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_SUB    = 2'd1;
   localparam logic [1:0] MODE_MUL    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [IDX_W-1:0] coef_index;
      coef_type         coef_value;
   } req_type;

   typedef struct packed {
      logic [DEG_W-1:0] term_degree;
      acc_type          term_value;
      logic             last_term;
   } rsp_type;

   typedef struct packed {
      logic clr;
      logic start;
      logic step;
   } cell_ctrl_type;

endpackage

### rtl/pasm_cell.sv
module pasm_cell
   import pasm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          we_a,
   input  logic          we_b,
   input  coef_type      wdata,
   input  coef_type      x,
   input  acc_type       s_in,
   output coef_type      a,
   output coef_type      b,
   output acc_type       sum,
   output acc_type       s
);

   coef_type a_ff, a_in;
   coef_type b_ff, b_in;
   acc_type  s_ff, s_in_nxt;
   logic signed [PROD_W-1:0] prod;

   assign prod = a_ff * x;
   assign sum  = s_in + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctrl.clr) begin
         a_in = '0;
         b_in = '0;
      end else begin
         if (we_a) a_in = wdata;
         if (we_b) b_in = wdata;
      end
   end

   // The partial sum travels towards cell zero, one cell on each step.
   always_comb begin
      s_in_nxt = s_ff;
      if (ctrl.start) s_in_nxt = '0;
      else if (ctrl.step) s_in_nxt = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      s_ff <= s_in_nxt;
   end

   assign a = a_ff;
   assign b = b_ff;
   assign s = s_ff;

endmodule

### rtl/polynomial_add_sub_mul_unit.sv
// Load, clear and unused-mode compute beats are taken back to back.
// A compute is followed by top+1 results, one per cycle when the output is free; the
// first is registered once the run state is entered and the output is free; the input stalls until the last.
// top is the larger degree for sum and difference, the sum of degrees for the product.
// The product runs through a transposed chain of 16 multiply-accumulate cells.
// Synchronous reset clears both stores, sets both degrees to 5 and op_mode to 0.
module polynomial_add_sub_mul_unit
   import pasm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [IDX_W-1:0] a_deg_ff, a_deg_in, b_deg_ff, b_deg_in;
   logic [DEG_W-1:0] cnt_ff, cnt_in, top_ff, top_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_ctrl_type    ctrl;
   logic             accept, out_free, advance, do_load;
   logic [STORE_DEPTH-1:0] we_a, we_b;
   coef_type         a_w [STORE_DEPTH];
   coef_type         b_w [STORE_DEPTH];
   acc_type          sum_w [STORE_DEPTH];
   acc_type          s_w [STORE_DEPTH+1];
   coef_type         x, a_sel, b_sel;
   acc_type          lin_val;

   assign req_stall = (state_ff == ST_RUN);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = (state_ff == ST_RUN) && out_free;
   assign do_load   = accept && (req_data.cmd == CMD_WRITE_A || req_data.cmd == CMD_WRITE_B)
                      && ({1'b0, req_data.coef_index} <= DEG_W'(MAX_DEGREE));

   assign a_sel = a_w[cnt_ff[IDX_W-1:0]];
   assign b_sel = b_w[cnt_ff[IDX_W-1:0]];
   assign x     = (cnt_ff[DEG_W-1] == 1'b0) ? b_sel : '0;

   always_comb begin
      lin_val = (mode_ff == MODE_SUB)
              ? ACC_W'(a_sel) - ACC_W'(b_sel)
              : ACC_W'(a_sel) + ACC_W'(b_sel);
   end

   always_comb begin
      ctrl.clr   = accept && (req_data.cmd == CMD_CLEAR);
      ctrl.start = accept && (req_data.cmd == CMD_COMPUTE);
      ctrl.step  = advance && (mode_ff == MODE_MUL);
      for (int k = 0; k < STORE_DEPTH; k++) begin
         we_a[k] = do_load && (req_data.cmd == CMD_WRITE_A)
                   && (req_data.coef_index == IDX_W'(k));
         we_b[k] = do_load && (req_data.cmd == CMD_WRITE_B)
                   && (req_data.coef_index == IDX_W'(k));
      end
   end

   assign s_w[STORE_DEPTH] = '0;

   for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
      pasm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .we_a  (we_a[k]),
         .we_b  (we_b[k]),
         .wdata (req_data.coef_value),
         .x     (x),
         .s_in  (s_w[k+1]),
         .a     (a_w[k]),
         .b     (b_w[k]),
         .sum   (sum_w[k]),
         .s     (s_w[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      a_deg_in     = a_deg_ff;
      b_deg_in     = b_deg_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.clr) begin
               a_deg_in = BASE_DEGREE;
               b_deg_in = BASE_DEGREE;
            end
            if (do_load && req_data.cmd == CMD_WRITE_A && req_data.coef_index > a_deg_ff)
               a_deg_in = req_data.coef_index;
            if (do_load && req_data.cmd == CMD_WRITE_B && req_data.coef_index > b_deg_ff)
               b_deg_in = req_data.coef_index;
            if (ctrl.start && mode_ff != MODE_UNUSED) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               if (mode_ff == MODE_MUL)
                  top_in = {1'b0, a_deg_ff} + {1'b0, b_deg_ff};
               else
                  top_in = {1'b0, (a_deg_ff > b_deg_ff) ? a_deg_ff : b_deg_ff};
            end
         end
         ST_RUN: begin
            if (advance) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.term_degree  = cnt_ff;
               rsp_data_in.term_value   = (mode_ff == MODE_MUL) ? sum_w[0] : lin_val;
               rsp_data_in.last_term    = (cnt_ff == top_ff);
               cnt_in                   = cnt_ff + 1'b1;
               if (cnt_ff == top_ff) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ADD;
         a_deg_ff     <= BASE_DEGREE;
         b_deg_ff     <= BASE_DEGREE;
         cnt_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         a_deg_ff     <= a_deg_in;
         b_deg_ff     <= b_deg_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_deg_floor: assert property (@(posedge clock) disable iff (reset)
      a_deg_ff >= BASE_DEGREE && b_deg_ff >= BASE_DEGREE)
      else $error("store degree below base");

   cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff <= top_ff)
      else $error("term counter past top degree");

   last_ends_run: assert property (@(posedge clock) disable iff (reset)
      advance && cnt_ff == top_ff |=> state_ff == ST_IDLE && rsp_data_ff.last_term)
      else $error("last term did not end the run");

   no_req_while_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> !accept)
      else $error("beat taken during a run");

endmodule

### tb/testbench.sv
module testbench
   import pasm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [1:0] csr_wdata = '0;

   polynomial_add_sub_mul_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state, kept apart from the block's own.
   coef_type   poly_a [STORE_DEPTH];
   coef_type   poly_b [STORE_DEPTH];
   int         deg_a, deg_b;
   logic [1:0] cur_mode;

   req_type pending_beats[$];
   rsp_type expected_terms[$];
   int      mismatches = 0;
   int      bad_shown = 0;
   int      long_hold = 0;
   bit      burst_on = 1'b0;
   int      burst_left = 0;
   int      stall_phase = 0;

   function automatic void clear_polys();
      foreach (poly_a[i]) begin
         poly_a[i] = '0;
         poly_b[i] = '0;
      end
      deg_a = BASE_DEGREE;
      deg_b = BASE_DEGREE;
   endfunction

   function automatic rsp_type make_term(int d, longint v, bit last);
      rsp_type t;
      t.term_degree = d[DEG_W-1:0];
      t.term_value  = v[ACC_W-1:0];
      t.last_term   = last;
      return t;
   endfunction

   // Applies one accepted beat to the predictor and queues the terms it yields.
   function automatic void predict_terms(req_type r);
      int     top;
      longint acc;
      case (r.cmd)
         CMD_WRITE_A: begin
            poly_a[r.coef_index] = r.coef_value;
            if (r.coef_index > deg_a) deg_a = r.coef_index;
         end
         CMD_WRITE_B: begin
            poly_b[r.coef_index] = r.coef_value;
            if (r.coef_index > deg_b) deg_b = r.coef_index;
         end
         CMD_CLEAR: clear_polys();
         default: begin
            if (cur_mode == MODE_ADD || cur_mode == MODE_SUB) begin
               top = (deg_a > deg_b) ? deg_a : deg_b;
               for (int i = 0; i <= top; i++) begin
                  acc = (cur_mode == MODE_ADD) ? longint'(poly_a[i]) + longint'(poly_b[i])
                                               : longint'(poly_a[i]) - longint'(poly_b[i]);
                  expected_terms.push_back(make_term(i, acc, i == top));
               end
            end else if (cur_mode == MODE_MUL) begin
               top = deg_a + deg_b;
               for (int d = 0; d <= top; d++) begin
                  acc = 0;
                  for (int i = 0; i <= deg_a; i++)
                     if (d >= i && d - i <= deg_b)
                        acc += longint'(poly_a[i]) * longint'(poly_b[d-i]);
                  expected_terms.push_back(make_term(d, acc, d == top));
               end
            end
         end
      endcase
   endfunction

   // Driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_terms(req_data);
         if (req_valid && req_stall) begin
            // payload held while stalled
         end else if (pending_beats.size() > 0 && (burst_on || burst_left > 0)) begin
            req_valid <= 1'b1;
            req_data  <= pending_beats.pop_front();
            if (burst_left > 0) burst_left <= burst_left - 1;
            else burst_on <= 1'b0;
         end else begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
               burst_left <= $urandom_range(1, 12);
         end
      end
   end

   // Receiver stall pattern, with a long hold-off whenever long_hold is set.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold <= long_hold - 1;
      end else if (stall_phase[8])
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_terms.size() == 0) begin
            mismatches++;
            if (bad_shown < 10) begin
               bad_shown++;
               $display("Unexpected term: deg %0d value %0d last %0b",
                        rsp_data.term_degree, rsp_data.term_value, rsp_data.last_term);
            end
         end else begin
            want = expected_terms.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (bad_shown < 10) begin
                  bad_shown++;
                  $display("Term mismatch: expected deg %0d value %0d last %0b, got deg %0d value %0d last %0b",
                           want.term_degree, want.term_value, want.last_term,
                           rsp_data.term_degree, rsp_data.term_value, rsp_data.last_term);
               end
            end
         end
      end
   end

   function automatic req_type beat(logic [1:0] c, int idx, int val);
      req_type r;
      r.cmd = c;
      r.coef_index = idx[IDX_W-1:0];
      r.coef_value = val[COEF_W-1:0];
      return r;
   endfunction

   function automatic int rand_coef();
      case ($urandom_range(0, 4))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_terms.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_mode(logic [1:0] m);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      cur_mode  = m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // A well-formed round: a few loads followed by a compute, sometimes a clear.
   task automatic queue_round(int n_loads, bit wide);
      for (int k = 0; k < n_loads; k++)
         pending_beats.push_back(beat(2'($urandom_range(0, 1)),
                                      wide ? $urandom_range(0, 15) : $urandom_range(0, 6),
                                      rand_coef()));
      pending_beats.push_back(beat(CMD_COMPUTE, $urandom_range(0, 15), rand_coef()));
      if ($urandom_range(0, 4) == 0)
         pending_beats.push_back(beat(CMD_CLEAR, $urandom_range(0, 15), rand_coef()));
   endtask

   initial begin
      logic [1:0] modes [4];
      clear_polys();
      cur_mode = MODE_ADD;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      burst_on = 1'b1;

      // Directed: defaults, extremes, top index, every command.
      pending_beats.push_back(beat(CMD_COMPUTE, 0, 0));
      pending_beats.push_back(beat(CMD_WRITE_A, 0, 32767));
      pending_beats.push_back(beat(CMD_WRITE_B, 0, -32768));
      pending_beats.push_back(beat(CMD_WRITE_B, 9, -1));
      pending_beats.push_back(beat(CMD_COMPUTE, 15, -1));
      drain();
      set_mode(MODE_SUB);
      pending_beats.push_back(beat(CMD_COMPUTE, 0, 0));
      drain();
      set_mode(MODE_MUL);
      for (int i = 0; i < 16; i++) begin
         pending_beats.push_back(beat(CMD_WRITE_A, i, -32768));
         pending_beats.push_back(beat(CMD_WRITE_B, i, -32768));
      end
      pending_beats.push_back(beat(CMD_COMPUTE, 0, 0));
      pending_beats.push_back(beat(CMD_CLEAR, 15, 32767));
      pending_beats.push_back(beat(CMD_COMPUTE, 0, 0));
      drain();
      set_mode(MODE_UNUSED);
      pending_beats.push_back(beat(CMD_COMPUTE, 0, 0));
      pending_beats.push_back(beat(CMD_WRITE_A, 3, 1234));
      drain();

      // Random phases over the add, sub and mul modes; the block is left to fill up once.
      modes = '{MODE_ADD, MODE_MUL, MODE_SUB, MODE_MUL};
      for (int ph = 0; ph < 4; ph++) begin
         set_mode(modes[ph]);
         if (ph == 1) long_hold = 300;
         for (int r = 0; r < 8; r++)
            queue_round($urandom_range(1, 12), $urandom_range(0, 3) == 0);
         for (int k = 0; k < 3; k++)
            pending_beats.push_back(beat(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                                         rand_coef()));
         drain();
      end

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
